### hdl/med3f_pkg.sv
// ----------------------------------------------------------------------------
// med3f_pkg - shared types and constants of the 3x3 median stream filter
// Register indexes, field widths and the pipeline stage records.
// ----------------------------------------------------------------------------
`default_nettype none

package med3f_pkg;

    localparam int PIX_W = 8;
    localparam int COL_W = 11;
    localparam int ROW_W = 12;
    localparam int CFG_W = 13;

    // Configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;
    localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;

    // Beat held while the line store read completes
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } fetch_stage_t;

    // Position of the window centre while the median is formed
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             border;
    } centre_stage_t;

endpackage

`default_nettype wire

### hdl/med3f_ram.sv
// ----------------------------------------------------------------------------
// med3f_ram - simple dual-port RAM with registered read
// One write port and one read port; a read at the address being written
// returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module med3f_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/median3x3_stream_filter_unit.sv
// ----------------------------------------------------------------------------
// median3x3_stream_filter_unit - 3x3 median filter on a raster pixel stream
// Two line stores and a 3x3 window produce the median of each neighbourhood.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_axis channel in raster order, one beat per pixel;
//   s_axis_tuser marks the first pixel of a frame. Each beat from the second
//   row onwards (past its first pixel) yields one result beat on m_axis for
//   the centre one row up and one column to the left, or two rows up at the
//   right edge for a row's first pixel: the median of its 3x3 neighbourhood,
//   or zero with the border flag set when it lies on the frame edge. The last
//   row of a frame is never emitted. Frame width and height are written
//   through the cfg port by the user only while idle; the block does not
//   enforce it. Throughput is one pixel per clock while the receiver does not
//   stall: each line store has a read port and a write port, and each is used
//   once per beat. A result passes the line store read at the accepting edge,
//   then the window update, then the median select into the output register.
//   Reset sets width 640 and height 480 and clears the position counters;
//   the line stores are not cleared, since a frame writes every entry before
//   a non-border window reads it. When the receiver stalls, the pipeline
//   holds its contents and s_axis_tready falls once every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module median3x3_stream_filter_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Pixel input
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] pixel_in
    input  wire logic [0:0]  s_axis_tuser,  // [0] frame_start
    // Filtered output
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,  // [7:0] median_out, [19:8] out_row,
                                            // [30:20] out_col, [31] zero
    output      logic [0:0]  m_axis_tuser,  // [0] is_border
    // Configuration
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);

    localparam int LIM = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int PW  = med3f_pkg::PIX_W;
    localparam int CW  = med3f_pkg::COL_W;
    localparam int RW  = med3f_pkg::ROW_W;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [11:0] width_cfg_reg;
    logic [12:0] height_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= med3f_pkg::WIDTH_RESET;
            height_cfg_reg <= med3f_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index[0])
                med3f_pkg::REG_FRAME_WIDTH:  width_cfg_reg  <= cfg_data[11:0];
                med3f_pkg::REG_FRAME_HEIGHT: height_cfg_reg <= cfg_data;
                default:                     width_cfg_reg  <= width_cfg_reg;
            endcase
        end
    end

    logic [11:0] w_eff;
    logic [12:0] h_eff;

    always_comb
    begin
        if (width_cfg_reg < 12'd3)
            w_eff = 12'd3;
        else if (width_cfg_reg > 12'(LIM))
            w_eff = 12'(LIM);
        else
            w_eff = width_cfg_reg;

        if (height_cfg_reg < 13'd3)
            h_eff = 13'd3;
        else if (height_cfg_reg > med3f_pkg::HEIGHT_LIMIT)
            h_eff = med3f_pkg::HEIGHT_LIMIT;
        else
            h_eff = height_cfg_reg;
    end

    // ------------------------------------------------------------------
    // Handshake chain
    // ------------------------------------------------------------------
    logic fetch_valid_reg;
    logic centre_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic centre_adv;
    logic centre_free;
    logic fetch_adv;
    logic accept;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign centre_adv    = centre_valid_reg && out_free;
    assign centre_free   = !centre_valid_reg || out_free;
    assign fetch_adv     = fetch_valid_reg && centre_free;
    assign s_axis_tready = !fetch_valid_reg || centre_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Position of the incoming pixel
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_pos;
    logic [RW-1:0] row_pos;

    always_comb
    begin
        logic [CW-1:0] c0;
        logic [RW-1:0] r0;
        logic [12:0]   r_inc;
        c0 = s_axis_tuser[0] ? '0 : col_reg;
        r0 = s_axis_tuser[0] ? '0 : row_reg;
        // A column past the width starts the next row
        if ({1'b0, c0} >= w_eff)
        begin
            col_pos = '0;
            r_inc   = {1'b0, r0} + 13'd1;
        end
        else
        begin
            col_pos = c0;
            r_inc   = {1'b0, r0};
        end
        row_pos = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];

        if (({1'b0, col_pos} + 12'd1) < w_eff)
        begin
            col_next = col_pos + 11'd1;
            row_next = row_pos;
        end
        else
        begin
            col_next = '0;
            row_next = (({1'b0, row_pos} + 13'd1) < h_eff) ? row_pos + 12'd1 : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores
    // ------------------------------------------------------------------
    logic [AW+CW-1:0]      col_pos_ext;
    logic [AW-1:0]         rd_addr;
    logic [AW+CW-1:0]      fetch_col_ext;
    logic [AW-1:0]         upper_waddr;
    logic [PW-1:0]         upper_rdata;
    logic [PW-1:0]         middle_rdata;
    med3f_pkg::fetch_stage_t fetch_reg;

    // Columns always lie below the store depth, so the upper bits are zero
    assign col_pos_ext   = {{AW{1'b0}}, col_pos};
    assign rd_addr       = col_pos_ext[AW-1:0];
    assign fetch_col_ext = {{AW{1'b0}}, fetch_reg.col};
    assign upper_waddr   = fetch_col_ext[AW-1:0];

    // The middle store takes the new pixel; the upper one takes what the
    // middle store held at that column.
    med3f_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_middle_store (
        .clk   (clk),
        .we    (accept),
        .waddr (rd_addr),
        .wdata (s_axis_tdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (middle_rdata)
    );

    med3f_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_upper_store (
        .clk   (clk),
        .we    (fetch_adv),
        .waddr (upper_waddr),
        .wdata (middle_rdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (upper_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            fetch_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fetch_reg.pix <= s_axis_tdata;
            fetch_reg.row <= row_pos;
            fetch_reg.col <= col_pos;
        end
    end

    // ------------------------------------------------------------------
    // Window and centre position
    // ------------------------------------------------------------------
    logic [PW-1:0] win_reg [9];
    logic          emit;
    med3f_pkg::centre_stage_t centre_next;
    med3f_pkg::centre_stage_t centre_reg;

    always_comb
    begin
        logic col_nz;
        col_nz = (fetch_reg.col != '0);
        emit   = (fetch_reg.row >= 12'd2) || ((fetch_reg.row == 12'd1) && col_nz);
        if (col_nz)
        begin
            centre_next.row = fetch_reg.row - 12'd1;
            centre_next.col = fetch_reg.col - 11'd1;
        end
        else
        begin
            // The first pixel of a row completes the right edge of the row
            // two above.
            centre_next.row = fetch_reg.row - 12'd2;
            centre_next.col = 11'(w_eff - 12'd1);
        end
        centre_next.border = (centre_next.row == '0)
                          || ({1'b0, centre_next.row} == (h_eff - 13'd1))
                          || (centre_next.col == '0)
                          || ({1'b0, centre_next.col} == (w_eff - 12'd1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (centre_free)
            begin
                centre_valid_reg <= fetch_adv && emit;
            end
            if (fetch_adv)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    win_reg[i] <= win_reg[i+3];
                end
                win_reg[6] <= upper_rdata;
                win_reg[7] <= middle_rdata;
                win_reg[8] <= fetch_reg.pix;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch_adv)
        begin
            centre_reg <= centre_next;
        end
    end

    // ------------------------------------------------------------------
    // Median by rank: the element with fewer than five smaller values and
    // at least five not greater is the fifth smallest.
    // ------------------------------------------------------------------
    logic [PW-1:0] median;

    always_comb
    begin
        logic [3:0] lt_cnt;
        logic [3:0] le_cnt;
        median = win_reg[0];
        for (int i = 8; i >= 0; i--)
        begin
            lt_cnt = '0;
            le_cnt = '0;
            for (int j = 0; j < 9; j++)
            begin
                lt_cnt = lt_cnt + {3'b000, (win_reg[j] <  win_reg[i])};
                le_cnt = le_cnt + {3'b000, (win_reg[j] <= win_reg[i])};
            end
            if ((lt_cnt <= 4'd4) && (le_cnt >= 4'd5))
            begin
                median = win_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [PW-1:0] out_median_reg;
    logic [RW-1:0] out_row_reg;
    logic [CW-1:0] out_col_reg;
    logic          out_border_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= centre_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (centre_adv)
        begin
            out_median_reg <= centre_reg.border ? '0 : median;
            out_row_reg    <= centre_reg.row;
            out_col_reg    <= centre_reg.col;
            out_border_reg <= centre_reg.border;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_col_reg, out_row_reg, out_median_reg};
    assign m_axis_tuser  = out_border_reg;

endmodule

`default_nettype wire

### tb/tb_median3x3_stream_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_median3x3_stream_filter_unit - testbench of the 3x3 median stream filter
// Drives raster pixel streams through several frame geometries, predicts each
// result beat from a private copy of the line stores, window and position,
// and checks every output beat field by field, mostly under random back-pressure.
// ----------------------------------------------------------------------------

module tb_median3x3_stream_filter_unit;

    localparam int LINE_DEPTH  = 2048;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [med3f_pkg::PIX_W-1:0] median;
        logic [med3f_pkg::ROW_W-1:0] row;
        logic [med3f_pkg::COL_W-1:0] col;
        logic                        border;
    } filt_result_t;

    class median_scoreboard;
        bit [7:0]     row_above [LINE_DEPTH];
        bit [7:0]     row_mid [LINE_DEPTH];
        bit [7:0]     win [9];
        int           col_pos;
        int           row_pos;
        bit [11:0]    width_reg;
        bit [12:0]    height_reg;
        filt_result_t median_q [$];
        int           mismatches;

        function new();
            foreach (row_above[i])
            begin
                row_above[i] = 8'd0;
                row_mid[i]   = 8'd0;
            end
            foreach (win[i])
                win[i] = 8'd0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = med3f_pkg::WIDTH_RESET;
            height_reg = med3f_pkg::HEIGHT_RESET;
            mismatches = 0;
        endfunction

        function int eff_w();
            int w;
            w = width_reg;
            if (w < 3)
                w = 3;
            if (w > LINE_DEPTH)
                w = LINE_DEPTH;
            return w;
        endfunction

        function int eff_h();
            int h;
            h = height_reg;
            if (h < 3)
                h = 3;
            if (h > int'(med3f_pkg::HEIGHT_LIMIT))
                h = int'(med3f_pkg::HEIGHT_LIMIT);
            return h;
        endfunction

        function void write_reg(logic idx, bit [12:0] data);
            if (idx == med3f_pkg::REG_FRAME_WIDTH)
                width_reg = data[11:0];
            else
                height_reg = data;
        endfunction

        function bit [7:0] median_of_window();
            bit [7:0] v [9];
            bit [7:0] t;
            int       j;
            foreach (win[i])
                v[i] = win[i];
            for (int i = 1; i < 9; i++)
            begin
                t = v[i];
                j = i - 1;
                while (j >= 0 && v[j] > t)
                begin
                    v[j + 1] = v[j];
                    j--;
                end
                v[j + 1] = t;
            end
            return v[4];
        endfunction

        function void note_pixel(bit [7:0] pix, bit fs);
            int           w;
            int           h;
            int           r;
            int           c;
            int           orow;
            int           ocol;
            bit [7:0]     up;
            bit [7:0]     mid;
            filt_result_t res;
            w = eff_w();
            h = eff_h();
            if (fs)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            // A column beyond a narrowed width starts the next row.
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h)
                row_pos = 0;
            r = row_pos;
            c = col_pos;
            up  = row_above[c];
            mid = row_mid[c];
            row_above[c] = mid;
            row_mid[c]   = pix;
            for (int i = 0; i < 6; i++)
                win[i] = win[i + 3];
            win[6] = up;
            win[7] = mid;
            win[8] = pix;
            if (r >= 2 || (r == 1 && c >= 1))
            begin
                if (c >= 1)
                begin
                    orow = r - 1;
                    ocol = c - 1;
                end
                else
                begin
                    orow = r - 2;
                    ocol = w - 1;
                end
                res.border = (orow == 0) || (orow == h - 1)
                          || (ocol == 0) || (ocol == w - 1);
                res.median = res.border ? 8'd0 : median_of_window();
                res.row    = orow[med3f_pkg::ROW_W-1:0];
                res.col    = ocol[med3f_pkg::COL_W-1:0];
                median_q.push_back(res);
            end
            if (c + 1 < w)
                col_pos = c + 1;
            else
            begin
                col_pos = 0;
                row_pos = (r + 1 < h) ? r + 1 : 0;
            end
        endfunction

        function void check_result(bit [31:0] data, bit border);
            filt_result_t exp_r;
            if (median_q.size() == 0)
            begin
                $display("%0t: unexpected result beat data=%h border=%0b",
                         $time, data, border);
                mismatches++;
                return;
            end
            exp_r = median_q.pop_front();
            if (data[7:0] != exp_r.median)
            begin
                $display("%0t: median expected %0d actual %0d", $time, exp_r.median, data[7:0]);
                mismatches++;
            end
            if (data[19:8] != exp_r.row)
            begin
                $display("%0t: row expected %0d actual %0d", $time, exp_r.row, data[19:8]);
                mismatches++;
            end
            if (data[30:20] != exp_r.col)
            begin
                $display("%0t: col expected %0d actual %0d", $time, exp_r.col, data[30:20]);
                mismatches++;
            end
            if (data[31] != 1'b0)
            begin
                $display("%0t: pad bit expected 0 actual %0b", $time, data[31]);
                mismatches++;
            end
            if (border != exp_r.border)
            begin
                $display("%0t: border expected %0b actual %0b", $time, exp_r.border, border);
                mismatches++;
            end
        endfunction

        function int pending();
            return median_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [12:0] cfg_data;

    median_scoreboard sb;
    int               send_gap_pct;
    int               recv_stall_pct;
    int               cycles;

    median3x3_stream_filter_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_median3x3_stream_filter_unit NOT OK");
            $finish;
        end
    end

    // The receiver decides its stall for the coming edge at each falling edge.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    task automatic push_pixel(input bit [7:0] pix, input bit fs);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= fs;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pixel(pix, fs);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
    endtask

    // Beats that produce no result may still be in the pipeline once the
    // queue is empty, so a few more cycles pass before a register write.
    task automatic write_reg(input logic idx, input bit [12:0] data);
        hold_until_drained();
        repeat (10) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    function automatic bit [7:0] pick_pixel();
        int kind;
        kind = $urandom_range(0, 3);
        case (kind)
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2: return 8'd100 + 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly whole frames with random content; some frame starts are left out
    // so the position wraps, and stray frame starts break frames apart.
    task automatic run_frames(input int n_items, input int noise_pct, input bit open_with_fs,
                              input bit pause_mid);
        int frame_len;
        int pos;
        bit fs;
        frame_len = sb.eff_w() * sb.eff_h();
        pos = open_with_fs ? 0 : 1;
        for (int i = 0; i < n_items; i++)
        begin
            if (pause_mid && i == n_items / 2)
                hold_until_drained();
            if (i == 0)
                fs = open_with_fs;
            else if (pos == 0)
                fs = ($urandom_range(0, 99) < 80);
            else
                fs = 1'b0;
            if ($urandom_range(0, 99) < noise_pct)
                fs = 1'b1;
            if (fs)
                pos = 0;
            pos++;
            if (pos == frame_len)
                pos = 0;
            push_pixel(pick_pixel(), fs);
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'd0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = med3f_pkg::REG_FRAME_WIDTH;
        cfg_data       = 13'd0;
        cycles         = 0;
        send_gap_pct   = 22;
        recv_stall_pct = 53;
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Widths and heights below the minimum clamp to 3.
        write_reg(med3f_pkg::REG_FRAME_WIDTH, 13'd1);
        write_reg(med3f_pkg::REG_FRAME_HEIGHT, 13'd0);

        // One full 3x3 frame: the only inner centre sees four 0, four 255, one 128.
        push_pixel(8'd255, 1'b1);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd128, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b0);
        // Without a frame start the position wraps into a new frame.
        for (int i = 9; i >= 1; i--)
            push_pixel(8'(i), 1'b0);
        // A frame start in the middle of a frame restarts the position.
        push_pixel(8'd200, 1'b0);
        push_pixel(8'd17, 1'b1);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b0);

        write_reg(med3f_pkg::REG_FRAME_WIDTH, 13'd5);
        write_reg(med3f_pkg::REG_FRAME_HEIGHT, 13'd4);
        run_frames(100, 3, 1'b1, 1'b0);

        send_gap_pct   = 53;
        recv_stall_pct = 22;
        // Narrowing while mid-frame; the height writes as all ones and clamps.
        write_reg(med3f_pkg::REG_FRAME_WIDTH, 13'd4);
        write_reg(med3f_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
        run_frames(80, 2, 1'b0, 1'b1);

        write_reg(med3f_pkg::REG_FRAME_WIDTH, 13'd7);
        write_reg(med3f_pkg::REG_FRAME_HEIGHT, 13'd5);
        run_frames(100, 3, 1'b1, 1'b0);

        write_reg(med3f_pkg::REG_FRAME_HEIGHT, 13'd3);
        run_frames(40, 0, 1'b0, 1'b0);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        // All-ones width is masked to 4095 and clamped to the full line length.
        write_reg(med3f_pkg::REG_FRAME_WIDTH, 13'h1FFF);
        write_reg(med3f_pkg::REG_FRAME_HEIGHT, 13'd3);
        run_frames(40, 0, 1'b1, 1'b0);

        write_reg(med3f_pkg::REG_FRAME_WIDTH, 13'd9);
        write_reg(med3f_pkg::REG_FRAME_HEIGHT, 13'd6);
        run_frames(60, 2, 1'b1, 1'b0);

        hold_until_drained();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_median3x3_stream_filter_unit OK");
        else
        begin
            if (sb.pending() > 0)
                $display("%0t: %0d expected results never arrived", $time, sb.pending());
            $display("tb_median3x3_stream_filter_unit NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/med3f_pkg.sv
hdl/med3f_ram.sv
hdl/median3x3_stream_filter_unit.sv
tb/tb_median3x3_stream_filter_unit.sv
